// File: rtl/tst_pkg.sv
// Shared types, opcodes and constants for the TFTP session tracker.
package tst_pkg;

    // Raw TFTP opcodes.
    localparam logic [15:0] OP_RRQ   = 16'd1;
    localparam logic [15:0] OP_WRQ   = 16'd2;
    localparam logic [15:0] OP_DATA  = 16'd3;
    localparam logic [15:0] OP_ACK   = 16'd4;
    localparam logic [15:0] OP_ERROR = 16'd5;
    localparam logic [15:0] OP_OACK  = 16'd6;
    localparam logic [15:0] OP_INFO  = 16'd255;

    // Error codes that may close a transfer-size probe.
    localparam logic [15:0] ERR_UNDEFINED = 16'd0;
    localparam logic [15:0] ERR_OPTION    = 16'd8;

    // Block size limits and reset value.
    localparam logic [15:0] BLKSIZE_MIN   = 16'd8;
    localparam logic [15:0] BLKSIZE_MAX   = 16'd65464;
    localparam logic [15:0] BLKSIZE_RESET = 16'd512;

    // Last block number before the 16-bit counter wraps.
    localparam logic [31:0] BLOCK_WRAP_MARK = 32'h0000_FFFF;
    localparam logic [31:0] EXPECTED_RESET  = 32'd1;
    localparam logic [31:0] EXPECTED_FIRST_DONE = 32'd2;

    // Error classification codes.
    localparam logic [1:0] ECLASS_NONE  = 2'd0;
    localparam logic [1:0] ECLASS_REAL  = 2'd1;
    localparam logic [1:0] ECLASS_PROBE = 2'd2;

    // Kind of the previous packet.
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_OACK  = 2'd2,
        KIND_OTHER = 2'd3
    } t_kind;

    // One packet summary.
    typedef struct packed {
        logic [15:0] op_code;
        logic [15:0] short_block_number;
        logic [15:0] payload_bytes;
        logic [15:0] error_number;
        logic        blksize_present;
        logic [15:0] blksize_value;
        logic        tsize_present;
    } t_pkt;

    // One result item.
    typedef struct packed {
        logic [31:0] full_block_number;
        logic        last_block;
        logic        wrap_ahead;
        logic        sequence_gap;
        logic        missing_seen;
        logic        blksize_rejected;
        logic [1:0]  error_class;
        logic        opcode_known;
        logic [15:0] current_block_size;
    } t_res;

    // Block number extension status.
    typedef struct packed {
        logic [31:0] full;
        logic        ahead;
        logic        equal;
    } t_ext;

endpackage

// File: rtl/tst_if.sv
// Valid/ready channel interfaces for packet summaries and results.
interface tst_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] op_code;
    logic [15:0] short_block_number;
    logic [15:0] payload_bytes;
    logic [15:0] error_number;
    logic        blksize_present;
    logic [15:0] blksize_value;
    logic        tsize_present;

    modport source (
        output valid, op_code, short_block_number, payload_bytes, error_number,
               blksize_present, blksize_value, tsize_present,
        input  ready
    );
    modport sink (
        input  valid, op_code, short_block_number, payload_bytes, error_number,
               blksize_present, blksize_value, tsize_present,
        output ready
    );
endinterface

interface tst_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] full_block_number;
    logic        last_block;
    logic        wrap_ahead;
    logic        sequence_gap;
    logic        missing_seen;
    logic        blksize_rejected;
    logic [1:0]  error_class;
    logic        opcode_known;
    logic [15:0] current_block_size;

    modport source (
        output valid, full_block_number, last_block, wrap_ahead, sequence_gap,
               missing_seen, blksize_rejected, error_class, opcode_known,
               current_block_size,
        input  ready
    );
    modport sink (
        input  valid, full_block_number, last_block, wrap_ahead, sequence_gap,
               missing_seen, blksize_rejected, error_class, opcode_known,
               current_block_size,
        output ready
    );
endinterface

// File: rtl/tst_ext.sv
// Extends a 16-bit block number to 32 bits against the expected block.
module tst_ext
    import tst_pkg::*;
(
    input  logic [31:0] i_expected,
    input  logic [15:0] i_short,
    output t_ext        o_ext
);

    logic [15:0] diff;
    logic        near_zero;
    logic [31:0] full;

    // Signed 16-bit distance from the short number up to the expected block.
    assign diff = i_expected[15:0] - i_short;

    // A positive distance larger than the expected block would reach below
    // zero, so the short number is taken as it is.
    assign near_zero = !diff[15] && (i_expected[31:15] == 17'd0)
                       && (i_expected[14:0] < diff[14:0]);

    assign full = near_zero ? {16'd0, i_short}
                            : i_expected - {{16{diff[15]}}, diff};

    // Compare against the expected block for sequencing.
    assign o_ext.full  = full;
    assign o_ext.ahead = full > i_expected;
    assign o_ext.equal = full == i_expected;

endmodule

// File: rtl/tst_seq.sv
// Conversation state and per-packet result logic.
module tst_seq
    import tst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_pkt i_pkt,
    output t_res o_res
);

    logic [15:0] r_block_size, n_block_size;
    logic        r_rrq_seen, n_rrq_seen;
    logic        r_tsize_asked, n_tsize_asked;
    t_kind       r_prev_kind, n_prev_kind;
    logic [31:0] r_expected, n_expected;
    logic        r_gap_flag, n_gap_flag;

    t_ext        ext;
    logic        probe;

    tst_ext u_ext (
        .i_expected (r_expected),
        .i_short    (i_pkt.short_block_number),
        .o_ext      (ext)
    );

    // The error codes and request state that point to a tsize probe.
    always_comb begin
        probe = ((i_pkt.error_number == ERR_UNDEFINED)
                 || (i_pkt.error_number == ERR_OPTION))
                && r_rrq_seen && r_tsize_asked
                && ((r_prev_kind == KIND_OACK)
                    || ((r_prev_kind == KIND_DATA)
                        && (r_expected == EXPECTED_FIRST_DONE)));
    end

    // Next state and result for the packet in the input register.
    always_comb begin
        n_block_size  = r_block_size;
        n_rrq_seen    = r_rrq_seen;
        n_tsize_asked = r_tsize_asked;
        n_prev_kind   = KIND_OTHER;
        n_expected    = r_expected;
        n_gap_flag    = r_gap_flag;

        o_res = '0;
        o_res.opcode_known = (i_pkt.op_code inside {[OP_RRQ:OP_OACK], OP_INFO});

        case (i_pkt.op_code)
            OP_RRQ: begin
                n_rrq_seen = 1'b1;
                if (i_pkt.tsize_present) begin
                    n_tsize_asked = 1'b1;
                end
            end
            OP_WRQ: begin
                n_rrq_seen = 1'b0;
            end
            OP_DATA: begin
                o_res.full_block_number = ext.full;
                if (ext.ahead) begin
                    n_expected         = ext.full + 32'd1;
                    n_gap_flag         = 1'b1;
                    o_res.sequence_gap = 1'b1;
                end else if (ext.equal) begin
                    n_expected = r_expected + 32'd1;
                end
                o_res.last_block = i_pkt.payload_bytes < r_block_size;
                o_res.wrap_ahead = (ext.full == BLOCK_WRAP_MARK)
                                   && (i_pkt.payload_bytes == r_block_size);
                n_prev_kind = KIND_DATA;
            end
            OP_ACK: begin
                o_res.full_block_number = ext.full;
            end
            OP_ERROR: begin
                o_res.error_class = probe ? ECLASS_PROBE : ECLASS_REAL;
            end
            OP_OACK: begin
                if (i_pkt.blksize_present) begin
                    if ((i_pkt.blksize_value < BLKSIZE_MIN)
                        || (i_pkt.blksize_value > BLKSIZE_MAX)) begin
                        o_res.blksize_rejected = 1'b1;
                    end else begin
                        n_block_size = i_pkt.blksize_value;
                    end
                end
                n_prev_kind = KIND_OACK;
            end
            default: begin
                n_prev_kind = KIND_OTHER;
            end
        endcase

        o_res.missing_seen       = n_gap_flag;
        o_res.current_block_size = n_block_size;
    end

    // State registers advance once per processed packet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size  <= BLKSIZE_RESET;
            r_rrq_seen    <= 1'b0;
            r_tsize_asked <= 1'b0;
            r_prev_kind   <= KIND_NONE;
            r_expected    <= EXPECTED_RESET;
            r_gap_flag    <= 1'b0;
        end else if (i_fire) begin
            r_block_size  <= n_block_size;
            r_rrq_seen    <= n_rrq_seen;
            r_tsize_asked <= n_tsize_asked;
            r_prev_kind   <= n_prev_kind;
            r_expected    <= n_expected;
            r_gap_flag    <= n_gap_flag;
        end
    end

endmodule

// File: rtl/tftp_session_tracker_core.sv
// TFTP session tracker: takes one packet summary per cycle and returns one
// result per packet. Each packet is captured in an input register, evaluated
// against the conversation state and placed in a result register, so a
// result passes through the input and result registers before it reaches
// the outputs. The block accepts a new packet every cycle as long
// as the result side keeps taking results; only a held result stalls the
// input. The state update of one packet is ready for the next one in the
// following cycle. Reset sets the block size to 512 and the expected block
// number to 1.
module tftp_session_tracker_core
    import tst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tst_in_if.sink     i_pkt,
    tst_out_if.source  o_res
);

    logic r_in_valid;
    t_pkt r_pkt;
    logic r_out_valid;
    t_res r_res;
    logic advance;
    t_res res;

    // The input register moves on when the result register is free or drains.
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_pkt.ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pkt.ready) begin
            r_in_valid <= i_pkt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pkt.valid && i_pkt.ready) begin
            r_pkt.op_code            <= i_pkt.op_code;
            r_pkt.short_block_number <= i_pkt.short_block_number;
            r_pkt.payload_bytes      <= i_pkt.payload_bytes;
            r_pkt.error_number       <= i_pkt.error_number;
            r_pkt.blksize_present    <= i_pkt.blksize_present;
            r_pkt.blksize_value      <= i_pkt.blksize_value;
            r_pkt.tsize_present      <= i_pkt.tsize_present;
        end
    end

    tst_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_pkt   (r_pkt),
        .o_res   (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.full_block_number  = r_res.full_block_number;
    assign o_res.last_block         = r_res.last_block;
    assign o_res.wrap_ahead         = r_res.wrap_ahead;
    assign o_res.sequence_gap       = r_res.sequence_gap;
    assign o_res.missing_seen       = r_res.missing_seen;
    assign o_res.blksize_rejected   = r_res.blksize_rejected;
    assign o_res.error_class        = r_res.error_class;
    assign o_res.opcode_known       = r_res.opcode_known;
    assign o_res.current_block_size = r_res.current_block_size;

endmodule

// File: rtl/tst_checker.sv
// Port-level checks for the TFTP session tracker, bound to the top level.
module tst_checker
    import tst_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_full_block_number,
    input logic        i_last_block,
    input logic        i_wrap_ahead,
    input logic        i_sequence_gap,
    input logic        i_missing_seen,
    input logic [1:0]  i_error_class,
    input logic [15:0] i_current_block_size
);

    // A stalled result keeps its block number.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_full_block_number))
        else $error("result changed while stalled");

    // A gap in this packet must show in the sticky gap flag.
    a_gap_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_sequence_gap |-> i_missing_seen)
        else $error("gap reported without missing flag");

    // A short block and an imminent wrap exclude each other.
    a_last_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_last_block && i_wrap_ahead))
        else $error("last block and wrap ahead both set");

    // The block size in force stays within the accepted range, and the error class is a defined code.
    a_bsize_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_current_block_size >= BLKSIZE_MIN)
                        && (i_current_block_size <= BLKSIZE_MAX)
                        && (i_error_class != 2'd3))
        else $error("block size or error class out of range");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind tftp_session_tracker_core tst_checker u_tst_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_out_valid          (o_res.valid),
    .i_out_ready          (o_res.ready),
    .i_full_block_number  (o_res.full_block_number),
    .i_last_block         (o_res.last_block),
    .i_wrap_ahead         (o_res.wrap_ahead),
    .i_sequence_gap       (o_res.sequence_gap),
    .i_missing_seen       (o_res.missing_seen),
    .i_error_class        (o_res.error_class),
    .i_current_block_size (o_res.current_block_size)
);
